// ===== rtl/core/bfd_pkg.sv =====
package bfd_pkg;

  localparam int DepthW    = 16;
  localparam int CoordW    = 12;
  localparam int CfgW      = 20;
  localparam int LinW      = 25;
  localparam int MaxHeight = 2048;
  localparam int QuoW      = DepthW;

  // Exponential table: ExpSize+1 samples of exp(-x) over x in [0, ExpRange]
  localparam int ExpSize   = 256;
  localparam int ExpRange  = 16;
  localparam int RomW      = 17;
  localparam int WeightW   = 17;
  localparam int XLimBit   = $clog2(ExpRange) + 16;
  localparam int FracBits  = XLimBit - $clog2(ExpSize);
  localparam int IdxW      = $clog2(ExpSize + 1);

  localparam int DdW   = 2 * DepthW;
  localparam int CtW   = DdW + CfgW;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SPACE  = 2'd2,
    REG_COLOR  = 2'd3
  } cfg_idx_t;

  typedef logic [RomW-1:0] rom_t [0:ExpSize];

  typedef struct packed {
    logic take;
    logic mul;
    logic adr;
    logic start;
    logic center;
    logic scan;
    logic div_start;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic scan_last;
    logic pipe_busy;
    logic div_done;
    logic out_free;
  } stat_t;

  // floor(a / d) by shift and subtract, used only while building the table
  function automatic longint unsigned div_u64(longint unsigned a, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], a[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-num/ExpSize) in Q31 from a 21-term Taylor series, each term truncated
  function automatic longint unsigned exp_neg_frac(longint unsigned num);
    longint unsigned term;
    longint unsigned plus;
    longint unsigned minus;
    term  = 64'd1 << 31;
    plus  = 64'd1 << 31;
    minus = 64'd0;
    for (int k = 1; k <= 20; k++) begin
      term = div_u64(term * num, 64'(ExpSize) * 64'(k));
      if ((k % 2) == 1) minus = minus + term;
      else plus = plus + term;
    end
    return plus - minus;
  endfunction

  function automatic rom_t build_exp_rom();
    rom_t rom;
    longint unsigned e1;
    longint unsigned en;
    longint unsigned ef;
    longint unsigned num;
    longint unsigned n;
    longint unsigned r;
    e1 = exp_neg_frac(64'(ExpSize));
    for (int i = 0; i <= ExpSize; i++) begin
      num = 64'(ExpRange) * 64'(i);
      n   = num / 64'(ExpSize);
      r   = num % 64'(ExpSize);
      en  = 64'd1 << 31;
      for (longint unsigned j = 0; j < n; j++) en = (en * e1 + (64'd1 << 30)) >> 31;
      ef = exp_neg_frac(r);
      rom[i] = RomW'((en * ef + (64'd1 << 45)) >> 46);
    end
    return rom;
  endfunction

endpackage

// ===== rtl/core/bfd_tap.sv =====
module bfd_tap #(
  parameter int D2W  = 7,
  parameter int TapW = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clear,
  input  logic                              in_vld,
  input  logic [bfd_pkg::DepthW-1:0]        tap,
  input  logic [D2W-1:0]                    dist2,
  input  logic [bfd_pkg::DepthW-1:0]        center,
  input  logic [bfd_pkg::CfgW-1:0]          space_coeff,
  input  logic [bfd_pkg::CfgW-1:0]          color_coeff,
  output logic [2*bfd_pkg::DepthW+TapW:0]   sum,
  output logic [bfd_pkg::WeightW+TapW-1:0]  wsum,
  output logic                              busy
);

  localparam int SdW  = D2W + bfd_pkg::CfgW;
  localparam int XW   = ((SdW > bfd_pkg::CtW) ? SdW : bfd_pkg::CtW) + 1;
  localparam int DW   = bfd_pkg::DepthW;
  localparam int WW   = bfd_pkg::WeightW;
  localparam int PW   = WW + DW;
  localparam bfd_pkg::rom_t ExpRom = bfd_pkg::build_exp_rom();

  logic v2, v3, v4, v5, v6, v7;
  logic [DW-1:0] t2, t3, t4, t5, t6;
  logic [bfd_pkg::DdW-1:0] dd2;
  logic [SdW-1:0] sd2, sd3;
  logic [bfd_pkg::CtW-1:0] ct3;
  logic big4, big5;
  logic [bfd_pkg::RomW-1:0] a4, b4, a5;
  logic [DW-1:0] frac4;
  logic dec5;
  logic [bfd_pkg::RomW+DW-1:0] prod5;
  logic [WW-1:0] wt6, w7;
  logic [PW-1:0] p7;

  logic [DW-1:0] dd;
  logic [XW-1:0] x;
  logic [bfd_pkg::IdxW-1:0] idx;
  logic [bfd_pkg::RomW-1:0] diff;
  logic [WW-1:0] step;

  assign dd   = (tap >= center) ? tap - center : center - tap;
  assign x    = XW'(sd3) + XW'(ct3);
  assign idx  = bfd_pkg::IdxW'(x[bfd_pkg::XLimBit-1:bfd_pkg::FracBits]);
  assign diff = dec5 ? '0 : '0;
  assign step = WW'(prod5[bfd_pkg::RomW+DW-1:DW]);

  logic [bfd_pkg::RomW-1:0] diff4;
  assign diff4 = (a4 >= b4) ? a4 - b4 : b4 - a4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v2 <= in_vld && (tap != '0);
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    t2    <= tap;
    dd2   <= bfd_pkg::DdW'(dd) * bfd_pkg::DdW'(dd);
    sd2   <= SdW'(dist2) * SdW'(space_coeff);
    t3    <= t2;
    ct3   <= bfd_pkg::CtW'(dd2) * bfd_pkg::CtW'(color_coeff);
    sd3   <= sd2;
    t4    <= t3;
    big4  <= |x[XW-1:bfd_pkg::XLimBit];
    a4    <= ExpRom[idx];
    b4    <= ExpRom[idx + 1'b1];
    frac4 <= {x[bfd_pkg::FracBits-1:0], (DW-bfd_pkg::FracBits)'(0)};
    t5    <= t4;
    big5  <= big4;
    a5    <= a4;
    dec5  <= a4 >= b4;
    prod5 <= (bfd_pkg::RomW+DW)'(diff4) * (bfd_pkg::RomW+DW)'(frac4);
    t6    <= t5;
    if (big5) wt6 <= '0;
    else if (dec5) wt6 <= a5 - step + diff;
    else wt6 <= a5 + step + diff;
    p7    <= PW'(wt6) * PW'(t6);
    w7    <= wt6;
  end

  // accumulate weighted depth and weight
  always_ff @(posedge clk) begin
    if (clear) begin
      sum  <= '0;
      wsum <= '0;
    end else if (v7) begin
      sum  <= sum + ($bits(sum))'(p7);
      wsum <= wsum + ($bits(wsum))'(w7);
    end
  end

  assign busy = v2 | v3 | v4 | v5 | v6 | v7;

endmodule

// ===== rtl/core/bfd_div.sv =====
module bfd_div #(
  parameter int DenW = 25
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [DenW+bfd_pkg::QuoW-1:0]      num,
  input  logic [DenW-1:0]                    den,
  output logic [bfd_pkg::QuoW-1:0]           quo,
  output logic                               done
);

  localparam int QW = bfd_pkg::QuoW;
  localparam int CW = $clog2(QW + 1);

  logic [DenW-1:0] rem;
  logic [QW-1:0]   low;
  logic [CW-1:0]   cnt;
  logic [DenW:0]   r2;
  logic            ge;

  assign r2 = {rem, low[QW-1]};
  assign ge = r2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(QW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) done <= 1'b1;
      end
    end
  end

  // quotient fits QW bits, so the upper dividend bits seed the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[DenW+QW-1:QW];
      low <= num[QW-1:0];
      quo <= '0;
    end else if (cnt != '0) begin
      rem <= ge ? DenW'(r2 - {1'b0, den}) : DenW'(r2);
      low <= {low[QW-2:0], 1'b0};
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/bfd_dp.sv =====
module bfd_dp #(
  parameter int MAX_WIDTH = 2048,
  parameter int RADIUS    = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bfd_pkg::CfgW-1:0]      cfg_data,
  input  logic                          in_mode,
  input  logic [bfd_pkg::DepthW-1:0]    in_depth,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfd_pkg::DepthW-1:0]    out_depth,
  output logic                          out_last,
  input  bfd_pkg::cmd_t                 cmd,
  output bfd_pkg::stat_t                stat
);

  localparam int CW    = bfd_pkg::CoordW;
  localparam int DW    = bfd_pkg::DepthW;
  localparam int LW    = bfd_pkg::LinW;
  localparam int Span  = 2 * RADIUS + 1;
  localparam int Taps  = Span * Span;
  localparam int TapW  = $clog2(Taps);
  localparam int SpanW = $clog2(Span);
  localparam int D2W   = $clog2(2 * RADIUS * RADIUS + 1);
  localparam int AddrW = $clog2((2 * RADIUS + 2) * MAX_WIDTH);
  localparam int WsW   = bfd_pkg::WeightW + TapW;

  // configuration
  logic [CW-1:0] width_r, height_r;
  logic [bfd_pkg::CfgW-1:0] space_r, color_r;
  logic [CW-1:0] w, h;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= CW'(640);
      height_r <= CW'(480);
      space_r  <= bfd_pkg::CfgW'(3641);
      color_r  <= bfd_pkg::CfgW'(36);
    end else if (cfg_we) begin
      unique case (bfd_pkg::cfg_idx_t'(cfg_index))
        bfd_pkg::REG_WIDTH:  width_r  <= cfg_data[CW-1:0];
        bfd_pkg::REG_HEIGHT: height_r <= cfg_data[CW-1:0];
        bfd_pkg::REG_SPACE:  space_r  <= cfg_data;
        bfd_pkg::REG_COLOR:  color_r  <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) w = CW'(1);
    else if ({1'b0, width_r} > (CW+1)'(MAX_WIDTH)) w = CW'(MAX_WIDTH);
    else w = width_r;
    if (height_r == '0) h = CW'(1);
    else if (height_r > CW'(bfd_pkg::MaxHeight)) h = CW'(bfd_pkg::MaxHeight);
    else h = height_r;
  end

  // position counters
  logic [CW-1:0] irow, icol, orow, ocol;
  logic [CW-1:0] n_irow, n_icol, n_orow, n_ocol;
  logic [DW-1:0] pix;
  logic          wr_en;

  always_comb begin
    n_irow = irow;
    n_icol = icol;
    n_orow = orow;
    n_ocol = ocol;
    if (n_icol >= w) begin
      n_icol = '0;
      n_irow = n_irow + 1'b1;
    end
    if (n_ocol >= w) begin
      n_ocol = '0;
      n_orow = n_orow + 1'b1;
    end
    if (n_orow >= h) begin
      n_irow = '0;
      n_icol = '0;
      n_orow = '0;
      n_ocol = '0;
    end
  end

  logic [LW-1:0] prod_in, prod_out, lag, cnt_r, kl_r;
  logic [LW-1:0] lin, kpos;
  logic [AddrW-1:0] caddr, rbase;
  logic [CW-1:0] icol_inc, ocol_inc, orow_inc;
  logic [CW-1:0] crow, ccol;
  logic          last_r;
  logic          last;

  assign lin      = prod_in + LW'(icol);
  assign kpos     = prod_out + LW'(ocol);
  assign icol_inc = icol + 1'b1;
  assign ocol_inc = ocol + 1'b1;
  assign orow_inc = orow + 1'b1;
  assign last     = (ocol_inc >= w) && (orow_inc >= h);

  always_ff @(posedge clk) begin
    if (rst) begin
      irow  <= '0;
      icol  <= '0;
      orow  <= '0;
      ocol  <= '0;
      wr_en <= 1'b0;
    end else if (cmd.take) begin
      irow  <= n_irow;
      icol  <= n_icol;
      orow  <= n_orow;
      ocol  <= n_ocol;
      wr_en <= !in_mode && (n_irow < h);
    end else if (cmd.adr && wr_en) begin
      if (icol_inc >= w) begin
        icol <= '0;
        irow <= irow + 1'b1;
      end else begin
        icol <= icol_inc;
      end
    end else if (cmd.start) begin
      if (last) begin
        irow <= '0;
        icol <= '0;
        orow <= '0;
        ocol <= '0;
      end else if (ocol_inc >= w) begin
        ocol <= '0;
        orow <= orow_inc;
      end else begin
        ocol <= ocol_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) pix <= in_depth;
    if (cmd.mul) begin
      prod_in  <= LW'(irow) * LW'(w);
      prod_out <= LW'(orow) * LW'(w);
      lag      <= LW'(RADIUS) * LW'(w) + LW'(RADIUS);
    end
    if (cmd.adr) begin
      cnt_r <= lin + LW'(wr_en);
      kl_r  <= kpos + lag;
      caddr <= AddrW'(kpos);
      rbase <= AddrW'(kpos - lag);
    end
    if (cmd.start) begin
      crow   <= orow;
      ccol   <= ocol;
      last_r <= last;
    end
  end

  assign stat.emit = (irow >= h) || (kl_r < cnt_r);

  // window scan
  logic [SpanW-1:0] di, dj;
  logic [AddrW-1:0] row_addr;
  logic [CW:0]      rsum, csum;
  logic             tap_ok;
  logic [SpanW-1:0] adi, adj;
  logic [D2W-1:0]   d2;

  assign rsum   = (CW+1)'(crow) + (CW+1)'(di);
  assign csum   = (CW+1)'(ccol) + (CW+1)'(dj);
  assign tap_ok = (rsum >= (CW+1)'(RADIUS)) && ((rsum - (CW+1)'(RADIUS)) < {1'b0, h})
               && (csum >= (CW+1)'(RADIUS)) && ((csum - (CW+1)'(RADIUS)) < {1'b0, w});
  assign adi    = (di >= SpanW'(RADIUS)) ? di - SpanW'(RADIUS) : SpanW'(RADIUS) - di;
  assign adj    = (dj >= SpanW'(RADIUS)) ? dj - SpanW'(RADIUS) : SpanW'(RADIUS) - dj;
  assign d2     = D2W'(adi) * D2W'(adi) + D2W'(adj) * D2W'(adj);
  assign stat.scan_last = (di == SpanW'(Span - 1)) && (dj == SpanW'(Span - 1));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      di       <= '0;
      dj       <= '0;
      row_addr <= rbase;
    end else if (cmd.scan) begin
      if (dj == SpanW'(Span - 1)) begin
        dj       <= '0;
        di       <= di + 1'b1;
        row_addr <= row_addr + AddrW'(w);
      end else begin
        dj <= dj + 1'b1;
      end
    end
  end

  // line memory
  logic [DW-1:0]    mem [0:(1<<AddrW)-1];
  logic [DW-1:0]    rdata;
  logic [AddrW-1:0] raddr;
  logic             rd_vld;
  logic [D2W-1:0]   rd_d2;
  logic [DW-1:0]    center;

  assign raddr = cmd.start ? caddr : row_addr + AddrW'(dj);

  always_ff @(posedge clk) begin
    if (cmd.adr && wr_en) mem[AddrW'(lin)] <= pix;
    if (cmd.start || cmd.scan) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) rd_vld <= 1'b0;
    else rd_vld <= cmd.scan && tap_ok;
    rd_d2 <= d2;
    if (cmd.center) center <= rdata;
  end

  logic [2*DW+TapW:0] sum;
  logic [WsW-1:0]     wsum;
  logic               tap_busy;
  logic [DW-1:0]      quo;

  bfd_tap #(.D2W(D2W), .TapW(TapW)) u_tap (
    .clk(clk), .rst(rst), .clear(cmd.start), .in_vld(rd_vld), .tap(rdata),
    .dist2(rd_d2), .center(center), .space_coeff(space_r), .color_coeff(color_r),
    .sum(sum), .wsum(wsum), .busy(tap_busy)
  );

  bfd_div #(.DenW(WsW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(sum), .den(wsum),
    .quo(quo), .done(stat.div_done)
  );

  assign stat.pipe_busy = rd_vld | tap_busy;
  assign stat.out_free  = !out_valid || out_ready;

  // result register; clamp to three times the center
  logic [DW+1:0] triple;
  assign triple = (DW+2)'(center) + (DW+2)'({center, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_last <= last_r;
      if (center == '0 || wsum == '0) out_depth <= '0;
      else if ((DW+2)'(quo) > triple) out_depth <= DW'(triple);
      else out_depth <= quo;
    end
  end

endmodule

// ===== rtl/core/bfd_ctrl.sv =====
module bfd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output bfd_pkg::cmd_t   cmd,
  input  bfd_pkg::stat_t  stat
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_ADR   = 9'b000000100,
    S_CMP   = 9'b000001000,
    S_CTR   = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_DRAIN = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.take      = (state == S_IDLE) && in_valid;
    cmd.mul       = (state == S_MUL);
    cmd.adr       = (state == S_ADR);
    cmd.start     = (state == S_CMP) && stat.emit;
    cmd.center    = (state == S_CTR);
    cmd.scan      = (state == S_SCAN);
    cmd.div_start = (state == S_DRAIN) && !stat.pipe_busy;
    cmd.load      = (state == S_OUT) && stat.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_MUL;
      S_MUL:   state_next = S_ADR;
      S_ADR:   state_next = S_CMP;
      S_CMP:   state_next = stat.emit ? S_CTR : S_IDLE;
      S_CTR:   state_next = S_SCAN;
      S_SCAN:  if (stat.scan_last) state_next = S_DRAIN;
      S_DRAIN: if (!stat.pipe_busy) state_next = S_DIV;
      S_DIV:   if (stat.div_done) state_next = S_OUT;
      S_OUT:   if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ===== rtl/core/depth_bilateral_filter_13x13_core.sv =====
// Bilateral filter for depth maps over a (2*RADIUS+1)^2 window.
// Input stream: one beat per item; tuser is the mode (0 pixel, 1 flush tick),
// tdata the raw depth (0 = invalid). Pixels arrive in raster order.
// Output stream: tdata is the filtered depth of the pixel RADIUS rows and
// RADIUS columns behind the input; tlast marks the last pixel of the frame.
// Once the whole frame is in, each flush beat (or extra pixel) drains one
// more result.
// Config port: write image_width (0), image_height (1), space_coeff (2),
// color_coeff (3) with cfg_we; only while the block is idle.
// Processing: a new input beat is taken only once the previous one is done. A
// beat that yields a result reads the window one tap per cycle through the
// single read port of the line memory, then a serial divider forms the
// quotient.
// Reset clears counters and restores the default configuration; the line
// memory needs no clearing. A stalled result waits in the output register
// while the next input beat is taken.
module depth_bilateral_filter_13x13_core #(
  parameter int MAX_WIDTH = 2048,
  parameter int RADIUS    = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] depth_in
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] depth_out
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  bfd_pkg::cmd_t  cmd;
  bfd_pkg::stat_t stat;

  bfd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cmd(cmd), .stat(stat)
  );

  bfd_dp #(.MAX_WIDTH(MAX_WIDTH), .RADIUS(RADIUS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_mode(s_axis_tuser[0]), .in_depth(s_axis_tdata),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_depth(m_axis_tdata), .out_last(m_axis_tlast),
    .cmd(cmd), .stat(stat)
  );

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken twice in a row");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> m_axis_tvalid)
    else $error("loaded result not presented");

endmodule
